// File: rtl/scda_pkg.sv
package scda_pkg;

    // field widths
    localparam int CMD_W   = 2;
    localparam int ROW_W   = 12;
    localparam int VAL_W   = 32;
    localparam int ACC_W   = 48;
    localparam int MODE_W  = 3;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int FRAC_W  = 16;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int ROW_COUNT_DEF = 4096;
    localparam logic [VAL_W-1:0] SCALE_RESET = 32'h0001_0000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 1'd1;

    // commands
    localparam logic [CMD_W-1:0] CMD_WR_DENSE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_WEIGHT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NONZERO   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RD_DENSE  = 2'd3;

    // operating modes
    localparam logic [MODE_W-1:0] MODE_DOT       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WDOT      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WNORM     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SCATTER   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WSCATTER  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL1,
        ST_SAT1,
        ST_MUL2,
        ST_SAT2,
        ST_SUM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic             sat;
    } word_sat_t;

    typedef struct packed {
        logic [ACC_W-1:0] val;
        logic             sat;
    } acc_sat_t;

    // drop the fraction bits of a q16.16 product (floor), clamp to 32 bits
    function automatic word_sat_t q_trunc(input logic [PROD_W-1:0] p);
        word_sat_t r;
        logic [PROD_W-FRAC_W-1:0] q;
        q = p[PROD_W-1:FRAC_W];
        if (q[PROD_W-FRAC_W-1:VAL_W-1] == {(PROD_W-FRAC_W-VAL_W+1){q[PROD_W-FRAC_W-1]}}) begin
            r.val = q[VAL_W-1:0];
            r.sat = 1'b0;
        end else begin
            r.val = q[PROD_W-FRAC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
            r.sat = 1'b1;
        end
        return r;
    endfunction

    // saturating 48-bit accumulate of a 32-bit term
    function automatic acc_sat_t acc_add(input logic [ACC_W-1:0] a, input logic [VAL_W-1:0] t);
        acc_sat_t r;
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {{(ACC_W-VAL_W+1){t[VAL_W-1]}}, t};
        if (s[ACC_W] == s[ACC_W-1]) begin
            r.val = s[ACC_W-1:0];
            r.sat = 1'b0;
        end else begin
            r.val = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            r.sat = 1'b1;
        end
        return r;
    endfunction

    // saturating 32-bit add for the dense store
    function automatic word_sat_t word_add(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] t);
        word_sat_t r;
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {t[VAL_W-1], t};
        if (s[VAL_W] == s[VAL_W-1]) begin
            r.val = s[VAL_W-1:0];
            r.sat = 1'b0;
        end else begin
            r.val = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage

// File: rtl/scda_ram.sv
module scda_ram
    import scda_pkg::*;
#(
    parameter int WIDTH = VAL_W,
    parameter int DEPTH = ROW_COUNT_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sparse_column_dot_axpy_unit.sv
// per item: a read steps through fetch and emit; a nonzero through fetch, then no multiply
// (spare modes), one multiply and saturate pair (single product modes) or two (two product
// modes), then sum, and emit on a last nonzero; an entry write is stored when accepted;
// one item at a time on the shared 32x32 multiplier and registered-read stores
// reset: synchronous, active low; clears sequencer, accumulator, sticky flag, output valid,
// op_mode to 0 and scale_factor to 1.0; store contents stay undefined until written
module sparse_column_dot_axpy_unit
    import scda_pkg::*;
#(
    parameter int ROW_COUNT = ROW_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,

    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // row_index[11:0], value[43:12], zero pad
    input  logic [CMD_W-1:0]      s_tuser,   // command[1:0]
    input  logic                  s_tlast,   // last_element

    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // result[47:0], saturated[48], zero pad
);

    localparam int ADDR_W = $clog2(ROW_COUNT);

    // input field slices
    logic [ROW_W-1:0] s_row;
    logic [VAL_W-1:0] s_value;
    logic             s_xfer;
    logic             s_in_range;

    assign s_row      = s_tdata[ROW_W-1:0];
    assign s_value    = s_tdata[ROW_W+VAL_W-1:ROW_W];
    assign s_xfer     = s_tvalid && s_tready;
    // rows past the store depth are ignored on write and read as zero
    assign s_in_range = 32'(s_row) < 32'(ROW_COUNT);

    // configuration registers
    logic [MODE_W-1:0] op_mode_reg;
    logic [VAL_W-1:0]  scale_reg;

    // sequencer and item registers
    state_t            state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [VAL_W-1:0]  val_reg;
    logic              last_reg;
    logic              in_range_reg;

    // shared multiplier datapath
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [VAL_W-1:0]  term_reg, term_next;
    logic [VAL_W-1:0]  mul_a, mul_b;
    word_sat_t         prod_trunc;

    // reduction state
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              sticky_reg, sticky_next;

    // output register
    logic                 m_tvalid_reg;
    logic [ACC_W-1:0]     m_result_reg;
    logic                 m_sat_reg;
    logic                 out_free;

    // store ports
    logic              dense_we, weight_we, store_re;
    logic [ADDR_W-1:0] dense_waddr, rd_addr;
    logic [VAL_W-1:0]  dense_wdata;
    logic [VAL_W-1:0]  dense_rd, weight_rd;
    logic [VAL_W-1:0]  dense_ent, weight_ent;

    // mode decode
    logic scatter_mode, two_mul_mode, known_mode;
    acc_sat_t  acc_sum;
    word_sat_t dense_sum;

    assign scatter_mode = (op_mode_reg == MODE_SCATTER) || (op_mode_reg == MODE_WSCATTER);
    assign two_mul_mode = (op_mode_reg == MODE_WDOT) || (op_mode_reg == MODE_WNORM)
                       || (op_mode_reg == MODE_WSCATTER);
    // modes above the weighted scatter add contribute zero terms
    assign known_mode   = (op_mode_reg == MODE_DOT) || two_mul_mode
                       || (op_mode_reg == MODE_SCATTER);

    assign out_free   = !m_tvalid_reg || m_tready;
    assign dense_ent  = in_range_reg ? dense_rd  : '0;
    assign weight_ent = in_range_reg ? weight_rd : '0;

    // dense store: written by entry commands and by scatter add writeback
    scda_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ROW_COUNT)
    ) u_dense_ram (
        .aclk    (aclk),
        .wr_en   (dense_we),
        .wr_addr (dense_waddr),
        .wr_data (dense_wdata),
        .rd_en   (store_re),
        .rd_addr (rd_addr),
        .rd_data (dense_rd)
    );

    // weight store: written by entry commands only
    scda_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ROW_COUNT)
    ) u_weight_ram (
        .aclk    (aclk),
        .wr_en   (weight_we),
        .wr_addr (rd_addr),
        .wr_data (s_value),
        .rd_en   (store_re),
        .rd_addr (rd_addr),
        .rd_data (weight_rd)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer && (s_tuser == CMD_NONZERO || s_tuser == CMD_RD_DENSE)) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (cmd_reg == CMD_RD_DENSE) begin
                    state_next = ST_EMIT;
                end else if (known_mode) begin
                    state_next = ST_MUL1;
                end else begin
                    state_next = ST_SUM;
                end
            end
            ST_MUL1: state_next = ST_SAT1;
            ST_SAT1: state_next = two_mul_mode ? ST_MUL2 : ST_SUM;
            ST_MUL2: state_next = ST_SAT2;
            ST_SAT2: state_next = ST_SUM;
            ST_SUM:  state_next = last_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and store port control
    always_comb begin
        s_tready    = 1'b0;
        store_re    = 1'b0;
        dense_we    = 1'b0;
        weight_we   = 1'b0;
        dense_waddr = ADDR_W'(s_row);
        dense_wdata = s_value;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                store_re  = s_xfer;
                dense_we  = s_xfer && s_in_range && (s_tuser == CMD_WR_DENSE);
                weight_we = s_xfer && s_in_range && (s_tuser == CMD_WR_WEIGHT);
            end
            ST_SUM: begin
                // read-modify-write of the dense entry in the scatter modes
                dense_we    = scatter_mode && in_range_reg;
                dense_waddr = ADDR_W'(row_reg);
                dense_wdata = dense_sum.val;
            end
            default: begin
            end
        endcase
    end

    assign rd_addr = ADDR_W'(s_row);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = val_reg;
        mul_b = dense_ent;
        if (state_reg == ST_MUL2) begin
            mul_a = term_reg;
            mul_b = weight_ent;
        end else if (op_mode_reg == MODE_WNORM) begin
            mul_b = val_reg;
        end else if (scatter_mode) begin
            mul_b = scale_reg;
        end
    end

    assign prod_trunc = q_trunc(prod_reg);
    assign acc_sum    = acc_add(acc_reg, term_reg);
    assign dense_sum  = word_add(dense_ent, term_reg);

    // datapath next values
    always_comb begin
        prod_next   = prod_reg;
        term_next   = term_reg;
        acc_next    = acc_reg;
        sticky_next = sticky_reg;
        case (state_reg)
            ST_FETCH: term_next = '0;
            ST_MUL1, ST_MUL2: begin
                prod_next = PROD_W'($signed(mul_a) * $signed(mul_b));
            end
            ST_SAT1, ST_SAT2: begin
                term_next   = prod_trunc.val;
                sticky_next = sticky_reg || prod_trunc.sat;
            end
            ST_SUM: begin
                if (scatter_mode) begin
                    sticky_next = sticky_reg || (in_range_reg && dense_sum.sat);
                end else begin
                    acc_next    = acc_sum.val;
                    sticky_next = sticky_reg || acc_sum.sat;
                end
            end
            ST_EMIT: begin
                // a column end clears the reduction, a read leaves it alone
                if (out_free && cmd_reg != CMD_RD_DENSE) begin
                    acc_next    = '0;
                    sticky_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            acc_reg      <= '0;
            sticky_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            op_mode_reg  <= MODE_DOT;
            scale_reg    <= SCALE_RESET;
        end else begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            sticky_reg <= sticky_next;
            if (state_reg == ST_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_OP_MODE: op_mode_reg <= cfg_wr_data[MODE_W-1:0];
                    REG_SCALE:   scale_reg   <= cfg_wr_data[VAL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        term_reg <= term_next;
        if (s_xfer) begin
            cmd_reg      <= s_tuser;
            row_reg      <= s_row;
            val_reg      <= s_value;
            last_reg     <= s_tlast;
            in_range_reg <= s_in_range;
        end
        if (state_reg == ST_EMIT && out_free) begin
            if (cmd_reg == CMD_RD_DENSE) begin
                m_result_reg <= {{(ACC_W-VAL_W){dense_ent[VAL_W-1]}}, dense_ent};
                m_sat_reg    <= 1'b0;
            end else begin
                m_result_reg <= scatter_mode ? '0 : acc_reg;
                m_sat_reg    <= sticky_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-ACC_W-1){1'b0}}, m_sat_reg, m_result_reg};

`ifndef SYNTHESIS
    // a nonzero or read holds off the next transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (s_tuser == CMD_NONZERO || s_tuser == CMD_RD_DENSE)) |=> !s_tready)
        else $error("transfer taken while an item is in flight");

    // a new result only appears after the emit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside the emit step");

    // a column end leaves a cleared accumulator and sticky flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && cmd_reg != CMD_RD_DENSE)
        |=> (acc_reg == '0 && !sticky_reg))
        else $error("reduction not cleared at column end");
`endif

endmodule

// File: test/sparse_column_dot_axpy_unit_tb.sv
`timescale 1ns / 1ps

module sparse_column_dot_axpy_unit_tb;
    import scda_pkg::*;

    localparam int ROWS            = ROW_COUNT_DEF;
    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 4;
    localparam int STALL_LIMIT     = 2000;   // cycles with no transfer of any kind
    localparam int SETTLE_CYCLES   = 16;     // covers the longest nonzero plus the emit
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 750;
    localparam int PRESSURE_PHASE  = 3;

    localparam longint ACC_TOP    = 64'sd140737488355327;
    localparam longint ACC_BOTTOM = -ACC_TOP - 1;
    localparam longint WORD_TOP    = 64'sd2147483647;
    localparam longint WORD_BOTTOM = -WORD_TOP - 1;

    // op_mode codes with no function of their own
    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

    // kinds of directed plan steps
    localparam bit STEP_XFER = 1'b0;
    localparam bit STEP_REG  = 1'b1;

    typedef struct packed {
        logic [ACC_W-1:0] result;
        logic             saturated;
    } column_result_t;

    typedef struct packed {
        logic                 kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CMD_W-1:0]     cmd;
        logic [ROW_W-1:0]     row;
        logic [VAL_W-1:0]     value;
        logic                 last;
        logic                 has_exp;
        column_result_t       exp;
    } plan_step_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // row_index[11:0], value[43:12], zero pad
    logic [CMD_W-1:0]      s_tuser;    // command[1:0]
    logic                  s_tlast;    // last_element
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // result[47:0], saturated[48], zero pad

    always #(HALF_PERIOD) aclk = ~aclk;

    sparse_column_dot_axpy_unit #(
        .ROW_COUNT(ROWS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // ------------------------------------------------------------------
    // predictor state: private copies of both stores, the running sum,
    // the sticky flag and the two registers
    // ------------------------------------------------------------------
    int                       dense_copy  [ROWS];
    int                       weight_copy [ROWS];
    longint                   column_sum;
    bit                       column_sticky;
    logic [MODE_W-1:0]        mode_copy;
    int                       scale_copy;
    bit                       term_sat;      // saturation seen in the current nonzero
    column_result_t           expected_results[$];

    // typed expectation that travels with the transfer on the bus
    bit                       typed_valid;
    column_result_t           typed_entry;

    // rows that may be read: both stores written
    bit                       dense_set  [ROWS];
    bit                       weight_set [ROWS];
    bit                       row_ready  [ROWS];
    int                       ready_rows[$];

    // sender / receiver control
    int                       burst_left;
    bit                       hold_off_req;

    // run bookkeeping
    int                       fail_count;
    int                       transfers_in;
    int                       results_checked;
    int                       reg_writes;
    int                       columns_closed;

    plan_step_t               plan[$];

    // clamp to the signed 32-bit range, noting any clip
    function automatic int clamp_word(input longint s);
        if (s > WORD_TOP) begin
            term_sat = 1'b1;
            return int'(WORD_TOP);
        end
        if (s < WORD_BOTTOM) begin
            term_sat = 1'b1;
            return int'(WORD_BOTTOM);
        end
        return int'(s);
    endfunction

    // q16.16 product, fraction dropped toward minus infinity
    function automatic int q16_product(input int a, input int b);
        longint p;
        p = (longint'(a) * longint'(b)) >>> FRAC_W;
        return clamp_word(p);
    endfunction

    // advance the predictor by one accepted transfer
    task automatic predict_column_step(input logic [CMD_W-1:0] cmd,
                                       input logic [ROW_W-1:0] row,
                                       input int val, input logic last);
        int             d;
        int             t;
        longint         s;
        column_result_t r;
        term_sat = 1'b0;
        case (cmd)
            CMD_WR_DENSE:  dense_copy[row] = val;
            CMD_WR_WEIGHT: weight_copy[row] = val;
            CMD_RD_DENSE: begin
                s = dense_copy[row];
                r.result = s[ACC_W-1:0];
                r.saturated = 1'b0;
                expected_results.push_back(typed_valid ? typed_entry : r);
            end
            CMD_NONZERO: begin
                if (mode_copy == MODE_SCATTER || mode_copy == MODE_WSCATTER) begin
                    d = q16_product(val, scale_copy);
                    if (mode_copy == MODE_WSCATTER)
                        d = q16_product(d, weight_copy[row]);
                    dense_copy[row] = clamp_word(longint'(dense_copy[row]) + longint'(d));
                end else begin
                    case (mode_copy)
                        MODE_DOT:   t = q16_product(val, dense_copy[row]);
                        MODE_WDOT:  t = q16_product(q16_product(val, dense_copy[row]),
                                                    weight_copy[row]);
                        MODE_WNORM: t = q16_product(q16_product(val, val), weight_copy[row]);
                        default:    t = 0;   // spare modes add nothing
                    endcase
                    s = column_sum + longint'(t);
                    if (s > ACC_TOP) begin
                        s = ACC_TOP;
                        term_sat = 1'b1;
                    end
                    if (s < ACC_BOTTOM) begin
                        s = ACC_BOTTOM;
                        term_sat = 1'b1;
                    end
                    column_sum = s;
                end
                column_sticky = column_sticky | term_sat;
                if (last) begin
                    // scatter columns report only the flag
                    if (mode_copy == MODE_SCATTER || mode_copy == MODE_WSCATTER)
                        r.result = '0;
                    else
                        r.result = column_sum[ACC_W-1:0];
                    r.saturated = column_sticky;
                    expected_results.push_back(typed_valid ? typed_entry : r);
                    column_sum = 0;
                    column_sticky = 1'b0;
                    columns_closed++;
                end
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // monitor: check each result transfer, then feed accepted inputs to
    // the predictor (a result never belongs to an input of the same edge)
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : bus_monitor
        column_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: result %h saturated %b",
                       m_tdata[ACC_W-1:0], m_tdata[ACC_W]);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[ACC_W-1:0] !== want.result) begin
                    $error("result mismatch: expected %h, actual %h",
                           want.result, m_tdata[ACC_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[ACC_W] !== want.saturated) begin
                    $error("saturated mismatch: expected %b, actual %b",
                           want.saturated, m_tdata[ACC_W]);
                    fail_count++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            transfers_in++;
            predict_column_step(s_tuser, s_tdata[ROW_W-1:0], s_tdata[ROW_W +: VAL_W], s_tlast);
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern in stretches of random density, with one
    // long hold-off on request so the block backs up into its input
    // ------------------------------------------------------------------
    initial begin : result_sink
        int ready_pct;
        int pattern_left;
        m_tready = 1'b0;
        ready_pct = 100;
        pattern_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern_left = $urandom_range(8, 64);
                    case ($urandom_range(0, 3))
                        0:       ready_pct = 100;
                        1:       ready_pct = 75;
                        2:       ready_pct = 40;
                        default: ready_pct = 10;
                    endcase
                end
                pattern_left--;
                m_tready = ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transfer ends the run
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("** sparse_column_dot_axpy_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // sender: one transfer, in bursts with random gaps between them
    // ------------------------------------------------------------------
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                         input logic [VAL_W-1:0] val, input logic last,
                         input bit typed, input column_result_t typed_val);
        int gap;
        // keep track of rows safe to read
        if (cmd == CMD_WR_DENSE)
            dense_set[row] = 1'b1;
        if (cmd == CMD_WR_WEIGHT)
            weight_set[row] = 1'b1;
        if (dense_set[row] && weight_set[row] && !row_ready[row]) begin
            row_ready[row] = 1'b1;
            ready_rows.push_back(int'(row));
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            else
                gap = $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = cmd;
        s_tdata = {{(S_TDATA_W - ROW_W - VAL_W){1'b0}}, val, row};
        s_tlast = last;
        typed_valid = typed;
        typed_entry = typed_val;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering and let every outstanding item finish
    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid = 1'b0;
        typed_valid = 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge aclk);
        // a trailing write or open nonzero may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data = data;
        @(posedge aclk);
        if (idx == REG_OP_MODE)
            mode_copy = data[MODE_W-1:0];
        else
            scale_copy = data;
        reg_writes++;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // directed plan entries
    task automatic plan_xfer(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                             input logic [VAL_W-1:0] val, input logic last);
        plan_step_t p;
        p = '0;
        p.kind = STEP_XFER;
        p.cmd = cmd;
        p.row = row;
        p.value = val;
        p.last = last;
        plan.push_back(p);
    endtask

    task automatic plan_check(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                              input logic [VAL_W-1:0] val, input logic last,
                              input logic [ACC_W-1:0] res, input logic sat);
        plan_step_t p;
        p = '0;
        p.kind = STEP_XFER;
        p.cmd = cmd;
        p.row = row;
        p.value = val;
        p.last = last;
        p.has_exp = 1'b1;
        p.exp = {res, sat};
        plan.push_back(p);
    endtask

    task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        plan_step_t p;
        p = '0;
        p.kind = STEP_REG;
        p.reg_index = idx;
        p.value = data;
        plan.push_back(p);
    endtask

    // random field values, weighted toward the interesting corners
    function automatic logic [VAL_W-1:0] pick_value();
        int v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
            end
            1, 2:    return $urandom;
            default: begin
                // within +-8.0, where sums stay mostly in range
                v = $urandom_range(0, 1 << 20) - (1 << 19);
                return v;
            end
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_scale();
        int v;
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return SCALE_RESET;
            default: begin
                v = $urandom_range(0, 1 << 19) - (1 << 18);
                return v;
            end
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        if ($urandom_range(0, 9) < 8)
            return MODE_W'($urandom_range(MODE_DOT, MODE_WSCATTER));
        return MODE_W'($urandom_range(MODE_WSCATTER + 1, MODE_SPARE));
    endfunction

    function automatic logic [ROW_W-1:0] pick_ready_row();
        return ROW_W'(ready_rows[$urandom_range(0, ready_rows.size() - 1)]);
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int             random_start;
        int             phase;
        int             phase_len;
        int             phase_start;
        int             col_len;
        logic [ROW_W-1:0] fresh_row;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_index = REG_OP_MODE;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_WR_DENSE;
        s_tlast = 1'b0;
        typed_valid = 1'b0;
        typed_entry = '0;
        hold_off_req = 1'b0;
        burst_left = 0;
        fail_count = 0;
        transfers_in = 0;
        results_checked = 0;
        reg_writes = 0;
        columns_closed = 0;
        column_sum = 0;
        column_sticky = 1'b0;
        mode_copy = MODE_DOT;
        scale_copy = SCALE_RESET;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed plan: registers at reset value first
        plan_xfer(CMD_WR_DENSE, 12'd0, 32'h0001_0000, 1'b0);
        plan_xfer(CMD_WR_WEIGHT, 12'd0, 32'h0002_0000, 1'b0);
        plan_xfer(CMD_WR_DENSE, 12'd4095, 32'h8000_0000, 1'b0);
        plan_xfer(CMD_WR_WEIGHT, 12'd4095, 32'h7FFF_FFFF, 1'b0);
        // reads: plain and sign extended
        plan_check(CMD_RD_DENSE, 12'd0, 32'h0, 1'b0, 48'h0000_0001_0000, 1'b0);
        plan_check(CMD_RD_DENSE, 12'd4095, 32'h0, 1'b0, 48'hFFFF_8000_0000, 1'b0);
        // dot at reset mode: 3.0 * 1.0
        plan_check(CMD_NONZERO, 12'd0, 32'h0003_0000, 1'b1, 48'h0000_0003_0000, 1'b0);
        // product clipped at the negative end
        plan_check(CMD_NONZERO, 12'd4095, 32'h7FFF_FFFF, 1'b1, 48'hFFFF_8000_0000, 1'b1);
        // two-term column, first term clipped positive, flag sticks to the end
        plan_xfer(CMD_NONZERO, 12'd4095, 32'h8000_0000, 1'b0);
        plan_xfer(CMD_NONZERO, 12'd0, 32'h0001_0000, 1'b1);
        // weighted dot: 1.0 * 1.0 * 2.0
        plan_reg(REG_OP_MODE, CFG_DATA_W'(MODE_WDOT));
        plan_check(CMD_NONZERO, 12'd0, 32'h0001_0000, 1'b1, 48'h0000_0002_0000, 1'b0);
        // weighted norm: 2.0^2 * 2.0
        plan_reg(REG_OP_MODE, CFG_DATA_W'(MODE_WNORM));
        plan_check(CMD_NONZERO, 12'd0, 32'h0002_0000, 1'b1, 48'h0000_0008_0000, 1'b0);
        // spare mode adds zero terms
        plan_reg(REG_OP_MODE, CFG_DATA_W'(MODE_SPARE));
        plan_check(CMD_NONZERO, 12'd4095, 32'h8000_0000, 1'b1, 48'h0, 1'b0);
        // scatter with reset scale: dense[0] becomes 2.0
        plan_reg(REG_OP_MODE, CFG_DATA_W'(MODE_SCATTER));
        plan_check(CMD_NONZERO, 12'd0, 32'h0001_0000, 1'b1, 48'h0, 1'b0);
        plan_check(CMD_RD_DENSE, 12'd0, 32'h0, 1'b0, 48'h0000_0002_0000, 1'b0);
        // scatter clipping both the product and the stored entry
        plan_reg(REG_SCALE, 32'h7FFF_FFFF);
        plan_check(CMD_NONZERO, 12'd4095, 32'h8000_0000, 1'b1, 48'h0, 1'b1);
        // weighted scatter, then a mode change in the middle of the column
        plan_reg(REG_OP_MODE, CFG_DATA_W'(MODE_WSCATTER));
        plan_reg(REG_SCALE, 32'h8000_0000);
        plan_xfer(CMD_NONZERO, 12'd0, 32'h0001_0000, 1'b0);
        plan_reg(REG_OP_MODE, CFG_DATA_W'(MODE_DOT));
        plan_xfer(CMD_NONZERO, 12'd0, 32'h0001_0000, 1'b1);
        plan_xfer(CMD_RD_DENSE, 12'd0, 32'h0, 1'b0);
        plan_xfer(CMD_RD_DENSE, 12'd4095, 32'hFFFF_FFFF, 1'b0);

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_REG) begin
                wait_quiet();
                write_reg(plan[i].reg_index, plan[i].value);
            end else begin
                issue(plan[i].cmd, plan[i].row, plan[i].value, plan[i].last,
                      plan[i].has_exp, plan[i].exp);
            end
        end

        // random phases, each under its own register setting
        random_start = transfers_in;
        phase = 0;
        while (transfers_in - random_start < RANDOM_ITEMS) begin
            wait_quiet();
            write_reg(REG_OP_MODE, CFG_DATA_W'(pick_mode()));
            if ($urandom_range(0, 1))
                write_reg(REG_SCALE, pick_scale());
            // long receiver hold-off while the sender keeps going
            if (phase == PRESSURE_PHASE)
                hold_off_req = 1'b1;
            phase_len = $urandom_range(40, 100);
            phase_start = transfers_in;
            while (transfers_in - phase_start < phase_len) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        // new row in both stores
                        fresh_row = ROW_W'($urandom_range(0, ROWS - 1));
                        issue(CMD_WR_DENSE, fresh_row, pick_value(), 1'b0, 1'b0, '0);
                        issue(CMD_WR_WEIGHT, fresh_row, pick_value(), 1'b0, 1'b0, '0);
                    end
                    2: begin
                        // noise: a lone write to either store
                        issue($urandom_range(0, 1) ? CMD_WR_WEIGHT : CMD_WR_DENSE,
                              ROW_W'($urandom_range(0, ROWS - 1)), pick_value(),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                    end
                    3: issue(CMD_RD_DENSE, pick_ready_row(), $urandom,
                             1'($urandom_range(0, 1)), 1'b0, '0);
                    default: begin
                        // a column; now and then the mark is left off so it runs on,
                        // possibly across a register change
                        col_len = $urandom_range(1, 6);
                        for (int j = 0; j < col_len; j++)
                            issue(CMD_NONZERO, pick_ready_row(), pick_value(),
                                  (j == col_len - 1) && ($urandom_range(0, 7) != 0),
                                  1'b0, '0);
                    end
                endcase
            end
            phase++;
        end

        wait_quiet();
        $display("covered %0d input transfers, %0d result transfers, %0d register writes",
                 transfers_in, results_checked, reg_writes);
        $display("%0d columns closed over %0d random phases, one with a long output stall",
                 columns_closed, phase);
        if (fail_count == 0) begin
            $display("** sparse_column_dot_axpy_unit: PASSED **");
        end else begin
            $display("** sparse_column_dot_axpy_unit: FAILED **");
        end
        $finish;
    end

endmodule
